[hdl/rtt_pkg.sv]
package rtt_pkg;
  localparam int SLOTS = 16;
  localparam int RATIO_BITS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int RATIO_W = RATIO_BITS + 1;
  localparam int QUE_DEPTH = 2;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_STOP    = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  localparam logic [1:0] MODE_SINGLE   = 2'd0;
  localparam logic [1:0] MODE_REPEAT   = 2'd1;
  localparam logic [1:0] MODE_BOUNCE   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [2:0] KIND_PROGRESS = 3'd0;
  localparam logic [2:0] KIND_STARTED  = 3'd1;
  localparam logic [2:0] KIND_STOPPED  = 3'd2;
  localparam logic [2:0] KIND_FINISHED = 3'd3;
  localparam logic [2:0] KIND_REJECTED = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] key;
    logic [31:0] duration;
    logic        start_reversed;
    logic [1:0]  mode;
    logic        wants_progress;
    logic        wants_status;
    logic [31:0] tick_amount;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        result_key;
    logic [2:0]         kind;
    logic [RATIO_W-1:0] ratio;
    logic               last;
  } res_t;
endpackage

[hdl/rtt_front.sv]
module rtt_front import rtt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  cmd_t       in_cmd,
  output logic       q_valid,
  input  logic       q_ready,
  output cmd_t       q_cmd
);
  // small queue; func three is dropped here
  cmd_t mem_r [QUE_DEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'(QUE_DEPTH));
  assign push = in_valid && in_ready && (in_cmd.func != FUNC_IGNORED);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

[hdl/rtt_div.sv]
module rtt_div import rtt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        num,
  input  logic [31:0]        den,
  output logic               done,
  output logic [RATIO_W-1:0] quo
);
  // restoring division of num*2^RATIO_BITS by den, num <= den
  logic [32:0] rem_r;
  logic [RATIO_W-1:0] q_r;
  logic [4:0] n_r;
  logic busy_r;
  logic [32:0] trial;
  logic [33:0] sh;

  assign sh = {rem_r, 1'b0};
  assign trial = sh[32:0] - {1'b0, den};
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= start ? (num == den) : (busy_r && n_r == 5'(RATIO_BITS - 1));
      if (start) begin
        rem_r <= {1'b0, num};
        n_r <= 5'd0;
        if (num == den) begin
          busy_r <= 1'b0;
          q_r <= RATIO_W'(1) << RATIO_BITS;
        end else begin
          busy_r <= 1'b1;
          q_r <= '0;
        end
      end else if (busy_r) begin
        if (sh[33:0] >= {2'b0, den}) begin
          rem_r <= trial;
          q_r <= {q_r[RATIO_W-2:0], 1'b1};
        end else begin
          rem_r <= sh[32:0];
          q_r <= {q_r[RATIO_W-2:0], 1'b0};
        end
        n_r <= n_r + 5'd1;
        if (n_r == 5'(RATIO_BITS - 1)) busy_r <= 1'b0;
      end
    end
  end
endmodule

[hdl/rtt_back.sv]
module rtt_back import rtt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIND   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_TSLOT  = 4'd3;
  localparam logic [3:0] S_TDIV   = 4'd4;
  localparam logic [3:0] S_TPROG  = 4'd5;
  localparam logic [3:0] S_TFIN   = 4'd6;
  localparam logic [3:0] S_TNEXT  = 4'd7;
  localparam logic [3:0] S_COMP   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [15:0] key_r [SLOTS];
  logic [31:0] dur_r [SLOTS];
  logic [31:0] ela_r [SLOTS];
  logic [SLOTS-1:0] rev_r, end_r;
  logic [1:0] mode_r [SLOTS];
  logic [1:0] flg_r [SLOTS];
  logic [CNT_W-1:0] live_r;

  logic [3:0] st_r, ret_r;
  cmd_t cmd_r;
  logic [CNT_W-1:0] i_r, w_r;
  logic found_r;
  logic [IDX_W-1:0] fidx_r;
  logic [31:0] t_r;
  logic pend_r;          // a result is held waiting for its successor
  res_t pend_res_r;
  res_t emit_res_r;
  logic ovalid_r;
  res_t ores_r;
  logic out_load;
  logic div_start, div_done;
  logic [RATIO_W-1:0] div_q;
  logic [IDX_W-1:0] ii;
  logic [32:0] sum;
  logic [31:0] t_nxt;

  assign ii = i_r[IDX_W-1:0];
  assign q_ready = (st_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_res = ores_r;
  assign sum = {1'b0, ela_r[ii]} + {1'b0, cmd_r.tick_amount};
  assign t_nxt = (sum > {1'b0, dur_r[ii]}) ? dur_r[ii] : sum[31:0];
  assign div_start = (st_r == S_TSLOT) && !end_r[ii] && flg_r[ii][0] && i_r < live_r;
  assign out_load = pend_r && (st_r == S_EMIT || st_r == S_DONE) && (!ovalid_r || out_ready);

  rtt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(t_nxt),
    .den(dur_r[ii]), .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      live_r <= '0;
      pend_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            i_r <= '0;
            found_r <= 1'b0;
            w_r <= '0;
            unique case (q_cmd.func)
              FUNC_TICK: st_r <= S_TSLOT;
              default:   st_r <= S_FIND;
            endcase
          end
        end
        S_FIND: begin
          if (i_r < live_r && !found_r) begin
            if (key_r[ii] == cmd_r.key) begin
              found_r <= 1'b1;
              fidx_r <= ii;
            end
            i_r <= i_r + CNT_W'(1);
          end else st_r <= S_START;
        end
        S_START: begin
          if (cmd_r.func == FUNC_STOP) begin
            if (found_r) end_r[fidx_r] <= 1'b1;
            if (found_r && cmd_r.wants_status) begin
              emit_res_r <= '{cmd_r.key, KIND_STOPPED, '0, 1'b0};
              ret_r <= S_DONE; st_r <= S_EMIT;
            end else st_r <= S_DONE;
          end else if (cmd_r.duration == 0 || (!found_r && live_r == CNT_W'(SLOTS))) begin
            emit_res_r <= '{cmd_r.key, KIND_REJECTED, '0, 1'b0};
            ret_r <= S_DONE; st_r <= S_EMIT;
          end else begin : load
            logic [IDX_W-1:0] k;
            k = found_r ? fidx_r : live_r[IDX_W-1:0];
            if (!found_r) begin
              live_r <= live_r + CNT_W'(1);
              key_r[k] <= cmd_r.key;
            end
            dur_r[k] <= cmd_r.duration;
            ela_r[k] <= '0;
            rev_r[k] <= cmd_r.start_reversed;
            mode_r[k] <= cmd_r.mode;
            flg_r[k] <= {cmd_r.wants_status, cmd_r.wants_progress};
            end_r[k] <= 1'b0;
            if (!cmd_r.wants_status) st_r <= S_DONE;
            else if (found_r) begin
              // stopped first, then started
              emit_res_r <= '{cmd_r.key, KIND_STOPPED, '0, 1'b0};
              ret_r <= S_COMP; st_r <= S_EMIT;
            end else begin
              emit_res_r <= '{cmd_r.key, KIND_STARTED, '0, 1'b0};
              ret_r <= S_DONE; st_r <= S_EMIT;
            end
          end
        end
        S_COMP: begin
          emit_res_r <= '{cmd_r.key, KIND_STARTED, '0, 1'b0};
          ret_r <= S_DONE; st_r <= S_EMIT;
        end
        S_TSLOT: begin
          if (i_r >= live_r) begin
            live_r <= w_r;
            st_r <= S_DONE;
          end else if (end_r[ii]) begin
            i_r <= i_r + CNT_W'(1);
          end else begin
            t_r <= t_nxt;
            st_r <= flg_r[ii][0] ? S_TDIV : S_TFIN;
          end
        end
        S_TDIV: begin
          // divider was started on the saturated total in the slot cycle
          if (div_done) begin
            emit_res_r <= '{key_r[ii], KIND_PROGRESS,
              rev_r[ii] ? (RATIO_W'(1) << RATIO_BITS) - div_q : div_q, 1'b0};
            ret_r <= S_TFIN; st_r <= S_EMIT;
          end
        end
        S_TFIN: begin
          if (t_r != dur_r[ii]) begin
            ela_r[ii] <= t_r;
            st_r <= S_TNEXT;
          end else begin
            ela_r[ii] <= '0;
            if (mode_r[ii] == MODE_BOUNCE) rev_r[ii] <= ~rev_r[ii];
            if (mode_r[ii] == MODE_SINGLE) end_r[ii] <= 1'b1;
            if (flg_r[ii][1]) begin
              emit_res_r <= '{key_r[ii], KIND_FINISHED, '0, 1'b0};
              ret_r <= S_TNEXT; st_r <= S_EMIT;
            end else st_r <= S_TNEXT;
          end
        end
        S_TNEXT: begin
          // compact: move slot i down to w if it stays
          if (!end_r[ii]) begin
            key_r[w_r[IDX_W-1:0]] <= key_r[ii];
            dur_r[w_r[IDX_W-1:0]] <= dur_r[ii];
            ela_r[w_r[IDX_W-1:0]] <= ela_r[ii];
            rev_r[w_r[IDX_W-1:0]] <= rev_r[ii];
            mode_r[w_r[IDX_W-1:0]] <= mode_r[ii];
            flg_r[w_r[IDX_W-1:0]] <= flg_r[ii];
            end_r[w_r[IDX_W-1:0]] <= 1'b0;
            w_r <= w_r + CNT_W'(1);
          end
          i_r <= i_r + CNT_W'(1);
          st_r <= S_TSLOT;
        end
        S_EMIT: begin
          // one result is held back so the final one can carry last
          if (!pend_r) begin
            pend_r <= 1'b1; pend_res_r <= emit_res_r; st_r <= ret_r;
          end else if (out_load) begin
            ores_r <= pend_res_r;
            pend_res_r <= emit_res_r; st_r <= ret_r;
          end
        end
        S_DONE: begin
          if (!pend_r) st_r <= S_IDLE;
          else if (out_load) begin
            ores_r <= '{pend_res_r.result_key, pend_res_r.kind, pend_res_r.ratio, 1'b1};
            pend_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/ramp_timer_table_top.sv]
// ramp timer table: up to 16 keyed ramps kept in start order. func 0 starts
// (or restarts) a ramp, func 1 stops it, func 2 advances every live ramp by
// tick_amount and reports progress (unsigned Q1.16) and finished results;
// results of one input transfer end with tlast. a start or stop does a linear
// key search, and a tick works out each progress ratio with a bit-serial
// divider; output stalls hold the block up. a two-entry queue decouples input.
module ramp_timer_table_top import rtt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: key, duration, start_reversed, mode, wants_progress,
  //        wants_status, tick_amount (from bit 0, zero padded)
  input  logic [87:0] s_tdata,
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: result_key, ratio (from bit 0, zero padded)
  output logic [39:0] m_tdata,
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast
);
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  res_t res;

  assign in_cmd = '{s_tuser, s_tdata[15:0], s_tdata[47:16], s_tdata[48],
                    s_tdata[50:49], s_tdata[51], s_tdata[52], s_tdata[84:53]};

  rtt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  rtt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_cmd(q_cmd), .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {7'd0, res.ratio, res.result_key};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;
endmodule

[sim/rtt_checker.sv]
module rtt_checker import rtt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  output int          mismatch_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] ramp_key [SLOTS];
  logic [31:0] ramp_len [SLOTS];
  logic [31:0] ramp_elapsed [SLOTS];
  logic        ramp_down [SLOTS];
  logic [1:0]  ramp_mode [SLOTS];
  logic [1:0]  ramp_flags [SLOTS];
  logic        ramp_ended [SLOTS];
  int          ramps_live;
  res_t        expected_results [$];

  function automatic void add_result(logic [15:0] k, logic [2:0] kd, logic [RATIO_W-1:0] r);
    res_t e;
    e.result_key = k;
    e.kind = kd;
    e.ratio = r;
    e.last = 1'b0;
    expected_results.push_back(e);
  endfunction

  function automatic int find_ramp(logic [15:0] k);
    for (int i = 0; i < ramps_live; i++)
      if (ramp_key[i] == k) return i;
    return -1;
  endfunction

  // advance the table by one input transfer and queue what it should produce
  function automatic void predict_ramps(cmd_t c);
    int first;
    int idx;
    int w;
    logic [63:0] d;
    logic [63:0] t;
    logic [63:0] r;
    first = expected_results.size();
    case (c.func)
      FUNC_START: begin
        idx = find_ramp(c.key);
        if (c.duration == 0) begin
          add_result(c.key, KIND_REJECTED, '0);
        end else if (idx < 0 && ramps_live >= SLOTS) begin
          add_result(c.key, KIND_REJECTED, '0);
        end else begin
          if (idx < 0) begin
            idx = ramps_live;
            ramps_live++;
            ramp_key[idx] = c.key;
          end else if (c.wants_status) begin
            add_result(c.key, KIND_STOPPED, '0);
          end
          ramp_len[idx] = c.duration;
          ramp_elapsed[idx] = '0;
          ramp_down[idx] = c.start_reversed;
          ramp_mode[idx] = c.mode;
          ramp_flags[idx] = {c.wants_status, c.wants_progress};
          ramp_ended[idx] = 1'b0;
          if (c.wants_status) add_result(c.key, KIND_STARTED, '0);
        end
      end
      FUNC_STOP: begin
        idx = find_ramp(c.key);
        if (idx >= 0) begin
          if (c.wants_status) add_result(c.key, KIND_STOPPED, '0);
          ramp_ended[idx] = 1'b1;
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < ramps_live; i++) begin
          if (ramp_ended[i]) continue;
          d = 64'(ramp_len[i]);
          t = 64'(ramp_elapsed[i]) + 64'(c.tick_amount);
          if (t > d) t = d;
          if (ramp_flags[i][0]) begin
            r = (t << RATIO_BITS) / d;
            if (ramp_down[i]) r = (64'd1 << RATIO_BITS) - r;
            add_result(ramp_key[i], KIND_PROGRESS, r[RATIO_W-1:0]);
          end
          if (t != d) begin
            ramp_elapsed[i] = t[31:0];
          end else begin
            if (ramp_mode[i] == MODE_BOUNCE) ramp_down[i] = ~ramp_down[i];
            if (ramp_flags[i][1]) add_result(ramp_key[i], KIND_FINISHED, '0);
            ramp_elapsed[i] = '0;
            if (ramp_mode[i] == MODE_SINGLE) ramp_ended[i] = 1'b1;
          end
        end
        // compact, keeping start order
        w = 0;
        for (int i = 0; i < ramps_live; i++) begin
          if (ramp_ended[i]) continue;
          ramp_key[w] = ramp_key[i];
          ramp_len[w] = ramp_len[i];
          ramp_elapsed[w] = ramp_elapsed[i];
          ramp_down[w] = ramp_down[i];
          ramp_mode[w] = ramp_mode[i];
          ramp_flags[w] = ramp_flags[i];
          ramp_ended[w] = 1'b0;
          w++;
        end
        ramps_live = w;
      end
      default: ;
    endcase
    if (expected_results.size() > first)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    cmd_t c;
    res_t e;
    res_t got;
    if (!rst_n) begin
      ramps_live = 0;
      expected_results.delete();
      mismatch_count <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        c.func = s_tuser;
        c.key = s_tdata[15:0];
        c.duration = s_tdata[47:16];
        c.start_reversed = s_tdata[48];
        c.mode = s_tdata[50:49];
        c.wants_progress = s_tdata[51];
        c.wants_status = s_tdata[52];
        c.tick_amount = s_tdata[84:53];
        predict_ramps(c);
      end
      if (m_tvalid && m_tready) begin
        got.result_key = m_tdata[15:0];
        got.ratio = m_tdata[16 +: RATIO_W];
        got.kind = m_tuser;
        got.last = m_tlast;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: key %h kind %0d ratio %0d last %b",
                     got.result_key, got.kind, got.ratio, got.last);
          mismatch_count <= mismatch_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e != got) begin
            if (mismatch_count < 10) begin
              $write("result mismatch: exp key %h kind %0d ratio %0d last %b, ",
                     e.result_key, e.kind, e.ratio, e.last);
              $display("got key %h kind %0d ratio %0d last %b",
                       got.result_key, got.kind, got.ratio, got.last);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_results <= expected_results.size();
  end
endmodule

[sim/ramp_timer_table_top_tb.sv]
module ramp_timer_table_top_tb import rtt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  int          mismatch_count;
  int          pending_results;
  int          quiet_cycles;
  bit          hold_request;
  bit          hold_done;
  int          burst_left;

  ramp_timer_table_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  rtt_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic cmd_t make_cmd(logic [1:0] f, logic [15:0] k, logic [31:0] dur,
                                    logic rev, logic [1:0] md, logic wp, logic ws,
                                    logic [31:0] amt);
    cmd_t c;
    c.func = f;
    c.key = k;
    c.duration = dur;
    c.start_reversed = rev;
    c.mode = md;
    c.wants_progress = wp;
    c.wants_status = ws;
    c.tick_amount = amt;
    return c;
  endfunction

  // random item: small key pool so restarts, stops and a full table happen often
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c = make_cmd('0, '0, '0, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), '0);
    pick = $urandom_range(0, 99);
    if (pick < 38) c.func = FUNC_START;
    else if (pick < 55) c.func = FUNC_STOP;
    else if (pick < 96) c.func = FUNC_TICK;
    else c.func = FUNC_IGNORED;  // unused code, block ignores it
    c.key = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 19)) : 16'($urandom);
    pick = $urandom_range(0, 99);
    c.duration = (pick < 70) ? $urandom_range(1, 60) : (pick < 80) ? 32'd0 : $urandom;
    pick = $urandom_range(0, 99);
    c.tick_amount = (pick < 60) ? $urandom_range(1, 20) : (pick < 70) ? 32'd0 : $urandom;
    return c;
  endfunction

  // one input transfer, sender gaps taken between bursts
  task automatic send_cmd(cmd_t c);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= c.func;
    s_tdata <= {3'b0, c.tick_amount, c.wants_status, c.wants_progress, c.mode,
                c.start_reversed, c.duration, c.key};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  // receiver stall pattern, plus one long hold-off to back up the input
  initial begin
    int run;
    int style;
    m_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      run = $urandom_range(1, 40);
      style = $urandom_range(0, 2);
      repeat (run) begin
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    cmd_t c;
    rst_n = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    hold_request = 1'b0;
    burst_left = 4;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero duration, fill the table, full rejection, restart,
    // stop of present and absent keys, revive of a stopped entry, max tick
    send_cmd(make_cmd(FUNC_START, 16'h0007, 32'd0, 1'b0, MODE_SINGLE, 1'b1, 1'b1, '0));
    for (int i = 0; i < SLOTS; i++)
      send_cmd(make_cmd(FUNC_START, (i == 0) ? 16'hFFFF : 16'(i),
                        (i == 1) ? 32'hFFFF_FFFF : 32'(10 + i), i[0], 2'(i % 4),
                        i[1] | (i == 0), i[2] | (i < 2), 32'hFFFF_FFFF));
    send_cmd(make_cmd(FUNC_START, 16'h0100, 32'd5, 1'b0, MODE_REPEAT, 1'b1, 1'b1, '0));
    send_cmd(make_cmd(FUNC_START, 16'd3, 32'd1, 1'b1, MODE_BOUNCE, 1'b1, 1'b1, '0));
    send_cmd(make_cmd(FUNC_STOP, 16'd5, '0, 1'b0, MODE_SINGLE, 1'b0, 1'b1, '0));
    send_cmd(make_cmd(FUNC_STOP, 16'd5, '0, 1'b0, MODE_SINGLE, 1'b0, 1'b1, '0));
    send_cmd(make_cmd(FUNC_STOP, 16'h0200, '0, 1'b0, MODE_SINGLE, 1'b0, 1'b1, '0));
    send_cmd(make_cmd(FUNC_START, 16'd5, 32'd4, 1'b0, MODE_RESERVED, 1'b1, 1'b1, '0));
    send_cmd(make_cmd(FUNC_TICK, '0, '0, 1'b0, MODE_SINGLE, 1'b0, 1'b0, 32'd0));
    send_cmd(make_cmd(FUNC_IGNORED, 16'd2, 32'd9, 1'b1, MODE_REPEAT, 1'b1, 1'b1, 32'd3));
    send_cmd(make_cmd(FUNC_TICK, '0, '0, 1'b0, MODE_SINGLE, 1'b0, 1'b0, 32'hFFFF_FFFF));

    // random part, with one long receiver hold-off partway through
    for (int n = 0; n < 134; n++) begin
      if (n == 60) hold_request = 1'b1;
      c = random_cmd();
      send_cmd(c);
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[filelist.f]
hdl/rtt_pkg.sv
hdl/rtt_front.sv
hdl/rtt_div.sv
hdl/rtt_back.sv
hdl/ramp_timer_table_top.sv
sim/rtt_checker.sv
sim/ramp_timer_table_top_tb.sv
